/* hw/rtl/tsp_pkg.sv */
// Shared types, constants and helper functions for the TCP SYN probe builder.
// No dependencies; imported by every module of the block.
package tsp_pkg;

   localparam int PROBE_WORDS  = 10;
   localparam int WORD_POS_W   = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W  = 8;

   localparam logic [WORD_POS_W-1:0] LAST_WORD_POS = WORD_POS_W'(PROBE_WORDS - 1);

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_ADDR = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_ADDR = CSR_INDEX_W'(1);

   // word positions
   localparam logic [WORD_POS_W-1:0] W_VER_LEN  = 4'd0;
   localparam logic [WORD_POS_W-1:0] W_ID_FRAG  = 4'd1;
   localparam logic [WORD_POS_W-1:0] W_TTL_CSUM = 4'd2;
   localparam logic [WORD_POS_W-1:0] W_SRC      = 4'd3;
   localparam logic [WORD_POS_W-1:0] W_DST      = 4'd4;
   localparam logic [WORD_POS_W-1:0] W_PORTS    = 4'd5;
   localparam logic [WORD_POS_W-1:0] W_SEQ      = 4'd6;
   localparam logic [WORD_POS_W-1:0] W_ACK      = 4'd7;
   localparam logic [WORD_POS_W-1:0] W_FLAGS    = 4'd8;
   localparam logic [WORD_POS_W-1:0] W_TCP_CSUM = 4'd9;

   // fixed header words
   localparam logic [31:0] IP_VER_LEN_WORD = 32'h4500_0028;   // v4, IHL 5, length 40
   localparam logic [15:0] IP_TTL_PROTO    = 16'h4006;        // TTL 64, TCP
   localparam logic [31:0] TCP_FLAGS_WORD  = 32'h5002_FFFF;   // offset 5, SYN, window

   // constant parts of both sums (all fixed 16-bit halves added up)
   localparam logic [19:0] IP_SUM_CONST  = 20'h0852E;  // 4500 + 0028 + 4006
   localparam logic [19:0] TCP_SUM_CONST = 20'h1501B;  // 0006 + 0014 + 5002 + ffff

   typedef struct packed {
      logic [15:0] local_port;
      logic [15:0] probed_port;
      logic [31:0] sequence_number;
      logic [15:0] ip_csum;
      logic [15:0] tcp_csum;
   } probe_type;

   // end-around carry fold of a raw sum, then ones' complement
   function automatic logic [15:0] csum_fold(input logic [19:0] raw);
      logic [16:0] a;
      logic [15:0] b;
      a = {1'b0, raw[15:0]} + 17'(raw[19:16]);
      b = a[15:0] + 16'(a[16]);
      return ~b;
   endfunction

   function automatic logic [31:0] probe_word(input probe_type p,
                                              input logic [WORD_POS_W-1:0] pos,
                                              input logic [31:0] src,
                                              input logic [31:0] dst);
      logic [31:0] w;
      case (pos)
         W_VER_LEN:  w = IP_VER_LEN_WORD;
         W_ID_FRAG:  w = 32'h0;
         W_TTL_CSUM: w = {IP_TTL_PROTO, p.ip_csum};
         W_SRC:      w = src;
         W_DST:      w = dst;
         W_PORTS:    w = {p.local_port, p.probed_port};
         W_SEQ:      w = p.sequence_number;
         W_ACK:      w = 32'h0;
         W_FLAGS:    w = TCP_FLAGS_WORD;
         W_TCP_CSUM: w = {p.tcp_csum, 16'h0};
         default:    w = 32'h0;
      endcase
      return w;
   endfunction

endpackage

/* hw/rtl/tsp_front.sv */
// Front end: accepts requests and works out both checksums in two stages.
// Depends on tsp_pkg.
module tsp_front
   import tsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [15:0] in_local_port,
   input  logic [15:0] in_probed_port,
   input  logic [31:0] in_sequence_number,
   input  logic [31:0] ip_source,
   input  logic [31:0] ip_target,
   output logic        out_valid,
   input  logic        out_ready,
   output probe_type   out_probe
);

   logic        s1_valid_ff, s1_valid_in;
   logic [15:0] s1_sport_ff, s1_dport_ff;
   logic [31:0] s1_seq_ff;
   logic [17:0] s1_addr_sum_ff, s1_item_sum_ff;

   logic        s2_valid_ff, s2_valid_in;
   logic [15:0] s2_sport_ff, s2_dport_ff;
   logic [31:0] s2_seq_ff;
   logic [19:0] s2_ip_raw_ff, s2_tcp_raw_ff;

   logic s1_ready, s2_ready, s1_load, s2_load;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;
   assign s1_load  = in_valid && s1_ready;
   assign s2_load  = s1_valid_ff && s2_ready;

   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s2_load || (s2_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_sport_ff    <= in_local_port;
         s1_dport_ff    <= in_probed_port;
         s1_seq_ff      <= in_sequence_number;
         s1_addr_sum_ff <= 18'(ip_source[31:16]) + 18'(ip_source[15:0])
                         + 18'(ip_target[31:16]) + 18'(ip_target[15:0]);
         s1_item_sum_ff <= 18'(in_local_port) + 18'(in_probed_port)
                         + 18'(in_sequence_number[31:16]) + 18'(in_sequence_number[15:0]);
      end
      if (s2_load) begin
         s2_sport_ff   <= s1_sport_ff;
         s2_dport_ff   <= s1_dport_ff;
         s2_seq_ff     <= s1_seq_ff;
         s2_ip_raw_ff  <= 20'(s1_addr_sum_ff) + IP_SUM_CONST;
         s2_tcp_raw_ff <= 20'(s1_addr_sum_ff) + 20'(s1_item_sum_ff) + TCP_SUM_CONST;
      end
   end

   assign out_valid                 = s2_valid_ff;
   assign out_probe.local_port      = s2_sport_ff;
   assign out_probe.probed_port     = s2_dport_ff;
   assign out_probe.sequence_number = s2_seq_ff;
   assign out_probe.ip_csum         = csum_fold(s2_ip_raw_ff);
   assign out_probe.tcp_csum        = csum_fold(s2_tcp_raw_ff);

endmodule

/* hw/rtl/tsp_queue.sv */
// Short queue of finished probe descriptors between front and back end.
// Depends on tsp_pkg.
module tsp_queue
   import tsp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  probe_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output probe_type out_data
);

   probe_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     push, pop;

   assign in_ready  = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= in_data;
   end

endmodule

/* hw/rtl/tsp_back.sv */
// Back end: serialises one probe descriptor into ten header words behind
// an output register. Depends on tsp_pkg.
module tsp_back
   import tsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  probe_type             in_probe,
   input  logic [31:0]           ip_source,
   input  logic [31:0]           ip_target,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [31:0]           out_word,
   output logic [WORD_POS_W-1:0] out_pos,
   output logic                  out_last
);

   probe_type             cur_ff, cur_in;
   logic                  active_ff, active_in;
   logic [WORD_POS_W-1:0] word_ff, word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [31:0]           rsp_word_ff, rsp_word_in;
   logic [WORD_POS_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  emit, at_last, free, take;

   assign emit    = active_ff && (!rsp_valid_ff || out_ready);
   assign at_last = word_ff == LAST_WORD_POS;
   // the next probe is loaded in the cycle its predecessor's last word goes out
   assign free     = !active_ff || (emit && at_last);
   assign in_ready = free;
   assign take     = in_valid && free;

   always_comb begin
      cur_in       = cur_ff;
      active_in    = active_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff && !out_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = probe_word(cur_ff, word_ff, ip_source, ip_target);
         rsp_pos_in   = word_ff;
         rsp_last_in  = at_last;
         word_in      = word_ff + 1'b1;
         if (at_last)
            active_in = 1'b0;
      end
      if (take) begin
         cur_in    = in_probe;
         word_in   = '0;
         active_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_word_ff <= rsp_word_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign out_valid = rsp_valid_ff;
   assign out_word  = rsp_word_ff;
   assign out_pos   = rsp_pos_ff;
   assign out_last  = rsp_last_ff;

endmodule

/* hw/rtl/tcp_syn_probe_builder_ipv4.sv */
// Top level of the TCP SYN probe builder: address registers, front end,
// descriptor queue and word serialiser. Depends on tsp_pkg and the tsp_* modules.
//
// Each request (local port, probed port, sequence number) yields one 40-byte
// IPv4+TCP SYN probe as ten 32-bit words on rsp_, first wire byte in bits
// 31..24, word index on rsp_tuser and rsp_tlast on word 9. Both checksums are
// computed in a two-stage front end; finished descriptors wait in a two-entry
// queue while the serialiser emits one word per cycle unless rsp_tready stalls
// it, so sustained throughput is set by the single 32-bit output channel. Each
// request's first word follows the front end, queue and descriptor register.
// Source and target addresses are written on the csr_ port (index 0 and 1;
// other indexes are ignored) and must only change while no probe is in flight.
module tcp_syn_probe_builder_ipv4
   import tsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [15:0] local_port, [31:16] probed_port, [63:32] sequence_number
   input  logic [63:0]            req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] packet_word
   output logic [31:0]            rsp_tdata,
   // [3:0] word_position
   output logic [WORD_POS_W-1:0]  rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   logic [31:0] ip_source_ff, ip_source_in;
   logic [31:0] ip_target_ff, ip_target_in;

   logic      fq_valid, fq_ready;
   probe_type fq_probe;
   logic      qb_valid, qb_ready;
   probe_type qb_probe;

   assign csr_ready = 1'b1;

   always_comb begin
      ip_source_in = ip_source_ff;
      ip_target_in = ip_target_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SOURCE_ADDR: ip_source_in = csr_data;
            CSR_TARGET_ADDR: ip_target_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_source_ff <= '0;
         ip_target_ff <= '0;
      end else begin
         ip_source_ff <= ip_source_in;
         ip_target_ff <= ip_target_in;
      end
   end

   tsp_front u_front (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (req_tvalid),
      .in_ready           (req_tready),
      .in_local_port      (req_tdata[15:0]),
      .in_probed_port     (req_tdata[31:16]),
      .in_sequence_number (req_tdata[63:32]),
      .ip_source          (ip_source_ff),
      .ip_target          (ip_target_ff),
      .out_valid          (fq_valid),
      .out_ready          (fq_ready),
      .out_probe          (fq_probe)
   );

   tsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_probe),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_probe)
   );

   tsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qb_valid),
      .in_ready  (qb_ready),
      .in_probe  (qb_probe),
      .ip_source (ip_source_ff),
      .ip_target (ip_target_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_tdata),
      .out_pos   (rsp_tuser),
      .out_last  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // tlast marks exactly the final word position
   a_last_pos : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == LAST_WORD_POS)))
      else $error("tlast does not match word position");

   // within a probe the words follow without gaps and in order
   a_word_seq : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 1'b1)))
      else $error("probe word skipped or stalled inside a probe");

   // a new probe always starts at word zero
   a_probe_start : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=>
         (!rsp_tvalid || (rsp_tuser == W_VER_LEN)))
      else $error("probe does not start at word zero");
`endif

endmodule

/* sim/probe_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the TCP SYN probe builder: watches the csr, request and response
// channels, predicts the ten words of each probe and compares them. Needs tsp_pkg.
module probe_checker
   import tsp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [63:0]            req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [31:0]            rsp_tdata,
   input  logic [WORD_POS_W-1:0]  rsp_tuser,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data,
   output int                     fail_count,
   output int                     words_pending
);

   localparam logic [7:0]  IP_VER_IHL  = 8'h45;
   localparam logic [15:0] IP_TOTAL    = 16'd40;
   localparam logic [7:0]  IP_TTL      = 8'd64;
   localparam logic [7:0]  PROTO_TCP   = 8'd6;
   localparam logic [15:0] TCP_LEN     = 16'd20;
   localparam logic [3:0]  TCP_OFFSET  = 4'd5;
   localparam logic [7:0]  TCP_SYN     = 8'h02;
   localparam logic [15:0] TCP_WINDOW  = 16'hFFFF;
   localparam int          REPORT_MAX  = 20;

   typedef struct packed {
      logic [31:0]           word;
      logic [WORD_POS_W-1:0] pos;
      logic                  last;
   } pkt_word_type;

   pkt_word_type words_due[$];
   logic [31:0]  ip_source;
   logic [31:0]  ip_target;

   function automatic logic [31:0] sum_halves(input logic [31:0] acc, input logic [31:0] w);
      return acc + {16'h0, w[31:16]} + {16'h0, w[15:0]};
   endfunction

   // end-around carry, then ones' complement; a zero result stays zero
   function automatic logic [15:0] fold_csum(input logic [31:0] acc);
      while (acc[31:16] != 16'h0)
         acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
      return ~acc[15:0];
   endfunction

   function automatic void queue_probe(input logic [15:0] sport, input logic [15:0] dport,
                                       input logic [31:0] seq);
      logic [31:0]  w [PROBE_WORDS];
      logic [31:0]  acc;
      pkt_word_type pw;
      int           k;
      w[W_VER_LEN]  = {IP_VER_IHL, 8'h00, IP_TOTAL};
      w[W_ID_FRAG]  = 32'h0;
      w[W_TTL_CSUM] = {IP_TTL, PROTO_TCP, 16'h0};
      w[W_SRC]      = ip_source;
      w[W_DST]      = ip_target;
      w[W_PORTS]    = {sport, dport};
      w[W_SEQ]      = seq;
      w[W_ACK]      = 32'h0;
      w[W_FLAGS]    = {TCP_OFFSET, 4'h0, TCP_SYN, TCP_WINDOW};
      w[W_TCP_CSUM] = 32'h0;
      acc = 32'h0;
      for (k = 0; k < 5; k++)
         acc = sum_halves(acc, w[k]);
      w[W_TTL_CSUM][15:0] = fold_csum(acc);
      // pseudo-header first, then the TCP header with its checksum still zero
      acc = sum_halves(32'h0, ip_source);
      acc = sum_halves(acc, ip_target);
      acc = sum_halves(acc, {8'h00, PROTO_TCP, TCP_LEN});
      for (k = 5; k < PROBE_WORDS; k++)
         acc = sum_halves(acc, w[k]);
      w[W_TCP_CSUM][31:16] = fold_csum(acc);
      for (k = 0; k < PROBE_WORDS; k++) begin
         pw.word = w[k];
         pw.pos  = WORD_POS_W'(k);
         pw.last = (k == PROBE_WORDS - 1);
         words_due.push_back(pw);
      end
   endfunction

   function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                         input logic [31:0] act_v);
      if (fail_count < REPORT_MAX)
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
      fail_count++;
   endfunction

   always @(posedge clock) begin
      pkt_word_type exp_w;
      if (reset) begin
         ip_source = 32'h0;
         ip_target = 32'h0;
         words_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SOURCE_ADDR: ip_source = csr_data;
               CSR_TARGET_ADDR: ip_target = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            queue_probe(req_tdata[15:0], req_tdata[31:16], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready) begin
            if (words_due.size() == 0) begin
               if (fail_count < REPORT_MAX)
                  $display("%0t: word %h with no probe outstanding", $time, rsp_tdata);
               fail_count++;
            end else begin
               exp_w = words_due.pop_front();
               if (rsp_tdata !== exp_w.word)
                  note_mismatch("packet word", exp_w.word, rsp_tdata);
               if (rsp_tuser !== exp_w.pos)
                  note_mismatch("word position", 32'(exp_w.pos), 32'(rsp_tuser));
               if (rsp_tlast !== exp_w.last)
                  note_mismatch("last word flag", 32'(exp_w.last), 32'(rsp_tlast));
            end
         end
      end
      words_pending = words_due.size();
   end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Top of the probe builder testbench: clock, reset, csr writes, probe requests and
// output back-pressure. Needs tsp_pkg, tcp_syn_probe_builder_ipv4 and probe_checker.
module tb
   import tsp_pkg::*;
;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PCT      = 16;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_PHASES = 5;
   localparam int PHASE_ITEMS   = 40;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_IDX = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_IDX   = 8'hFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [63:0]            req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [31:0]            rsp_tdata;
   logic [WORD_POS_W-1:0]  rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0]            csr_data = '0;

   int fail_count;
   int words_pending;
   int cycles;
   int hold_asked;
   int hold_seen;
   int hold_left;
   int probes_sent;
   int settings_used;
   bit gaps_on = 1'b1;

   tcp_syn_probe_builder_ipv4 uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   probe_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .fail_count(fail_count), .words_pending(words_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stalls (always ready while gaps are off), or a long hold-off whenever one is requested
   always @(posedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen  <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (gaps_on) begin
         rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_addresses(input logic [31:0] src, input logic [31:0] dst);
      write_csr(CSR_SOURCE_ADDR, src);
      write_csr(CSR_TARGET_ADDR, dst);
      settings_used++;
   endtask

   // valid is left high after a request so back-to-back requests need no toggle
   task automatic send_probe(input logic [15:0] sport, input logic [15:0] dport,
                             input logic [31:0] seq);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {seq, dport, sport};
      do @(posedge clock); while (!req_tready);
      probes_sent++;
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // addresses still at their reset value
      send_probe(16'h0000, 16'h0000, 32'h0000_0000);
      send_probe(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_probe(16'h8000, 16'h0001, 32'h8000_0001);
      settle();

      set_addresses(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_probe(16'h0000, 16'h0000, 32'h0000_0000);
      send_probe(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_probe(16'h1234, 16'h0050, 32'hDEAD_BEEF);
      settle();

      // IP sum folds to all ones with this source; writes to unused indexes must not land
      set_addresses(32'h7AD1_0000, 32'h0000_0000);
      write_csr(CSR_SPARE_IDX, $urandom());
      write_csr(CSR_TOP_IDX, $urandom());
      send_probe(16'h0000, 16'h0000, 32'h0000_0000);
      // local port chosen so the TCP checksum is zero too
      send_probe(16'h3512, 16'h0000, 32'h0000_0000);
      settle();

      set_addresses(32'h0000_0000, 32'hFFFF_FFFF);
      send_probe(16'hAAAA, 16'h5555, 32'h5A5A_A5A5);
      settle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         set_addresses($urandom(), $urandom());
         gaps_on = (p != 2);
         if (p == 1)
            hold_asked++;
         repeat (PHASE_ITEMS)
            send_probe(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                       $urandom());
         settle();
      end
      gaps_on = 1'b1;

      $display("Run covered %0d probes over %0d address settings, zero checksums,",
               probes_sent, settings_used);
      $display("ignored register indexes, a long output hold-off and a stall-free stretch.");
      if (fail_count == 0 && words_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/tsp_pkg.sv
hw/rtl/tsp_front.sv
hw/rtl/tsp_queue.sv
hw/rtl/tsp_back.sv
hw/rtl/tcp_syn_probe_builder_ipv4.sv
sim/probe_checker.sv
sim/tb.sv
